@@ hdl/tkwl_pkg.sv @@
// Shared types and constants for the counted trie k-th word lookup.
// No dependencies.
`timescale 1ns / 1ps

package tkwl_pkg;

   // Default geometry
   localparam int NODE_COUNT_DEF    = 1024;
   localparam int ALPHABET_SIZE_DEF = 26;
   localparam int MAX_DEPTH_DEF     = 32;

   // Field widths
   localparam int CHAR_W   = 8;
   localparam int RANK_W   = 16;
   localparam int COUNT_W  = 16;
   localparam int INFO_W   = COUNT_W + 1;
   localparam logic [CHAR_W-1:0] SYMBOL_BASE_RST = 8'd97;

   // Opcodes
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_END    = 3'd1;
   localparam logic [2:0] OP_STEP   = 3'd2;
   localparam logic [2:0] OP_QRESET = 3'd3;
   localparam logic [2:0] OP_KTH    = 3'd4;

   // Status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOTFOUND = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_BADCHAR  = 3'd3;
   localparam logic [2:0] ST_TOOLONG  = 3'd4;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_INS_ROW,
      S_INS_NEW,
      S_INS_CNT,
      S_END_WR,
      S_STEP_ROW,
      S_K_LVL,
      S_K_LVL_W,
      S_K_SCAN,
      S_K_CMP,
      S_EMIT,
      S_RESP
   } fsm_state_type;

endpackage

@@ hdl/trie_kth_word_lookup_top.sv @@
// Counted trie with k-th word lookup: control sequencer over a node row memory
// (child links, valid bits) and a node info memory (count, end mark). Uses tkwl_pkg, tkwl_ram.
// One item at a time. K-th word: per level, read the node row and info, then scan the
// children in order, comparing each present child's count with the rank; the word's
// characters then go out one per response. Result register parts the output side.
// Reset is synchronous; a clearing pass then clears the root row and info.
`timescale 1ns / 1ps

module trie_kth_word_lookup_top
   import tkwl_pkg::*;
#(
   parameter int NODE_COUNT    = NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
   parameter int MAX_DEPTH     = MAX_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_opcode,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [RANK_W-1:0] req_rank,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_out_char,
   output logic              rsp_empty_word,
   output logic              rsp_last,
   output logic [2:0]        rsp_status,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CHAR_W-1:0] csr_data
);

   localparam int NW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int AW    = $clog2(ALPHABET_SIZE);
   localparam int CW    = AW + 1;
   localparam int DW    = $clog2(MAX_DEPTH + 1);
   localparam int BW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int ROW_W = ALPHABET_SIZE + ALPHABET_SIZE * NW;

   fsm_state_type state_ff, state_in;

   logic [2:0]        op_ff, op_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [RANK_W-1:0] k_ff, k_in;
   logic [CHAR_W-1:0] base_ff, base_in;
   logic [NW:0]       used_ff, used_in;
   logic [NW-1:0]     icur_ff, icur_in;
   logic [DW-1:0]     idep_ff, idep_in;
   logic [NW-1:0]     qcur_ff, qcur_in;
   logic              qv_ff, qv_in;
   logic [NW-1:0]     node_ff, node_in;
   logic [NW-1:0]     nxt_ff, nxt_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic [DW-1:0]     len_ff, len_in;
   logic [DW-1:0]     emit_ff, emit_in;
   logic [AW-1:0]     word_ff [MAX_DEPTH];
   logic              word_we;
   logic [2:0]        stat_ff, stat_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [2:0]        rsp_stat_ff, rsp_stat_in;

   // memory ports
   logic              row_we, row_re, info_we, info_re;
   logic [NW-1:0]     row_wa, row_ra, info_wa, info_ra;
   logic [ROW_W-1:0]  row_wd, row_rd;
   logic [INFO_W-1:0] info_wd, info_rd;

   tkwl_ram #(.WIDTH(ROW_W), .DEPTH(NODE_COUNT)) u_row_mem (
      .clock(clock), .wr_en(row_we), .wr_addr(row_wa), .wr_data(row_wd),
      .rd_en(row_re), .rd_addr(row_ra), .rd_data(row_rd)
   );

   tkwl_ram #(.WIDTH(INFO_W), .DEPTH(NODE_COUNT)) u_info_mem (
      .clock(clock), .wr_en(info_we), .wr_addr(info_wa), .wr_data(info_wd),
      .rd_en(info_re), .rd_addr(info_ra), .rd_data(info_rd)
   );

   // decode helpers
   logic [CHAR_W-1:0]  sym_diff;
   logic               sym_bad;
   logic [AW-1:0]      sym_idx;
   logic [AW-1:0]      scan_idx;
   logic               scan_end;
   logic               slot_free;
   logic               child_ok;
   logic [NW-1:0]      child_link;
   logic               scan_ok;
   logic [NW-1:0]      scan_link;
   logic [COUNT_W-1:0] cnt;
   logic               cnt_fit;
   logic [RANK_W-1:0]  k_dec;
   logic               lvl_hit;
   logic               pool_full;
   logic               emit_last;
   logic               req_xfer;

   assign sym_diff   = char_ff - base_ff;
   assign sym_bad    = (char_ff < base_ff) || ({1'b0, sym_diff} >= 9'(ALPHABET_SIZE));
   assign sym_idx    = sym_diff[AW-1:0];
   assign scan_idx   = scan_ff[AW-1:0];
   assign scan_end   = (scan_ff == CW'(ALPHABET_SIZE));
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign child_ok   = row_rd[sym_idx];
   assign child_link = row_rd[ALPHABET_SIZE + sym_idx * NW +: NW];
   assign scan_ok    = row_rd[scan_idx];
   assign scan_link  = row_rd[ALPHABET_SIZE + scan_idx * NW +: NW];
   assign cnt        = info_rd[COUNT_W-1:0];
   assign cnt_fit    = (cnt >= k_ff);
   assign k_dec      = k_ff - 1'b1;
   assign lvl_hit    = info_rd[COUNT_W] && (k_dec == '0);
   assign pool_full  = (used_ff == (NW+1)'(NODE_COUNT));
   assign emit_last  = (len_ff == '0) || (emit_ff + 1'b1 == len_ff);
   assign req_xfer   = req_valid && req_ready;

   assign req_ready      = (state_ff == S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = rsp_char_ff;
   assign rsp_empty_word = rsp_empty_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_status     = rsp_stat_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: state_in = S_IDLE;
         S_IDLE: begin
            if (req_xfer) state_in = S_EXEC;
         end
         S_EXEC: begin
            case (op_ff)
               OP_INSERT: state_in = (sym_bad || idep_ff >= DW'(MAX_DEPTH)) ? S_RESP : S_INS_ROW;
               OP_END:    state_in = S_END_WR;
               OP_STEP:   state_in = (!qv_ff || sym_bad) ? S_RESP : S_STEP_ROW;
               OP_QRESET: state_in = S_RESP;
               OP_KTH:    state_in = (!qv_ff || k_ff == '0) ? S_RESP : S_K_LVL;
               default:   state_in = S_IDLE;
            endcase
         end
         S_INS_ROW: begin
            if (child_ok)       state_in = S_INS_CNT;
            else if (pool_full) state_in = S_RESP;
            else                state_in = S_INS_NEW;
         end
         S_INS_NEW:  state_in = S_RESP;
         S_INS_CNT:  state_in = S_RESP;
         S_END_WR:   state_in = S_RESP;
         S_STEP_ROW: state_in = S_RESP;
         S_K_LVL:    state_in = S_K_LVL_W;
         S_K_LVL_W: begin
            if (lvl_hit)                      state_in = S_EMIT;
            else if (len_ff >= DW'(MAX_DEPTH)) state_in = S_RESP;
            else                              state_in = S_K_SCAN;
         end
         S_K_SCAN: begin
            if (scan_end)     state_in = S_RESP;
            else if (scan_ok) state_in = S_K_CMP;
         end
         S_K_CMP: state_in = cnt_fit ? S_K_LVL : S_K_SCAN;
         S_EMIT: begin
            if (slot_free && emit_last) state_in = S_IDLE;
         end
         S_RESP: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      op_in   = op_ff;
      char_in = char_ff;
      k_in    = k_ff;
      base_in = base_ff;
      used_in = used_ff;
      icur_in = icur_ff;
      idep_in = idep_ff;
      qcur_in = qcur_ff;
      qv_in   = qv_ff;
      node_in = node_ff;
      nxt_in  = nxt_ff;
      scan_in = scan_ff;
      len_in  = len_ff;
      emit_in = emit_ff;
      stat_in = stat_ff;
      word_we = 1'b0;
      row_we  = 1'b0;
      row_wa  = icur_ff;
      row_wd  = row_rd;
      row_re  = 1'b0;
      row_ra  = icur_ff;
      info_we = 1'b0;
      info_wa = icur_ff;
      info_wd = info_rd;
      info_re = 1'b0;
      info_ra = icur_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_stat_in  = rsp_stat_ff;

      if (csr_valid && csr_ready) base_in = csr_data;

      case (state_ff)
         // clear root row and root info after reset
         S_CLEAR: begin
            row_we  = 1'b1;
            row_wa  = '0;
            row_wd  = '0;
            info_we = 1'b1;
            info_wa = '0;
            info_wd = '0;
         end
         S_IDLE: begin
            if (req_xfer) begin
               op_in   = req_opcode;
               char_in = req_char_code;
               k_in    = req_rank;
            end
         end
         S_EXEC: begin
            stat_in = ST_OK;
            case (op_ff)
               OP_INSERT: begin
                  if (sym_bad)                        stat_in = ST_BADCHAR;
                  else if (idep_ff >= DW'(MAX_DEPTH)) stat_in = ST_TOOLONG;
                  row_re = 1'b1;
                  row_ra = icur_ff;
               end
               OP_END: begin
                  info_re = 1'b1;
                  info_ra = icur_ff;
               end
               OP_STEP: begin
                  if (!qv_ff) begin
                     stat_in = ST_NOTFOUND;
                  end else if (sym_bad) begin
                     stat_in = ST_BADCHAR;
                     qv_in   = 1'b0;
                  end
                  row_re = 1'b1;
                  row_ra = qcur_ff;
               end
               OP_QRESET: begin
                  qcur_in = '0;
                  qv_in   = 1'b1;
               end
               OP_KTH: begin
                  if (!qv_ff || k_ff == '0) stat_in = ST_NOTFOUND;
                  node_in = qcur_ff;
                  len_in  = '0;
                  emit_in = '0;
               end
               default: ;
            endcase
         end
         // insert: follow or create the child
         S_INS_ROW: begin
            if (child_ok) begin
               nxt_in  = child_link;
               info_re = 1'b1;
               info_ra = child_link;
            end else if (pool_full) begin
               stat_in = ST_FULL;
            end else begin
               nxt_in  = used_ff[NW-1:0];
               used_in = used_ff + 1'b1;
               row_we  = 1'b1;
               row_wa  = icur_ff;
               row_wd  = row_rd;
               row_wd[sym_idx] = 1'b1;
               row_wd[ALPHABET_SIZE + sym_idx * NW +: NW] = used_ff[NW-1:0];
            end
         end
         S_INS_NEW: begin
            row_we  = 1'b1;
            row_wa  = nxt_ff;
            row_wd  = '0;
            info_we = 1'b1;
            info_wa = nxt_ff;
            info_wd = {1'b0, COUNT_W'(1)};
            icur_in = nxt_ff;
            idep_in = idep_ff + 1'b1;
         end
         S_INS_CNT: begin
            info_we = 1'b1;
            info_wa = nxt_ff;
            info_wd = {info_rd[COUNT_W], (cnt == '1) ? cnt : cnt + 1'b1};
            icur_in = nxt_ff;
            idep_in = idep_ff + 1'b1;
         end
         S_END_WR: begin
            info_we = 1'b1;
            info_wa = icur_ff;
            info_wd = {1'b1, cnt};
            icur_in = '0;
            idep_in = '0;
         end
         S_STEP_ROW: begin
            if (child_ok) begin
               qcur_in = child_link;
            end else begin
               qv_in   = 1'b0;
               stat_in = ST_NOTFOUND;
            end
         end
         // k-th word: one level per pass
         S_K_LVL: begin
            row_re  = 1'b1;
            row_ra  = node_ff;
            info_re = 1'b1;
            info_ra = node_ff;
         end
         S_K_LVL_W: begin
            if (info_rd[COUNT_W]) k_in = k_dec;
            scan_in = '0;
            stat_in = ST_NOTFOUND;
         end
         S_K_SCAN: begin
            if (!scan_end) begin
               if (scan_ok) begin
                  info_re = 1'b1;
                  info_ra = scan_link;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         S_K_CMP: begin
            if (cnt_fit) begin
               word_we = 1'b1;
               len_in  = len_ff + 1'b1;
               node_in = scan_link;
            end else begin
               k_in    = k_ff - cnt;
               scan_in = scan_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = (len_ff == '0);
               rsp_char_in  = (len_ff == '0) ? '0 :
                              base_ff + CHAR_W'(word_ff[emit_ff[BW-1:0]]);
               rsp_last_in  = emit_last;
               rsp_stat_in  = ST_OK;
               emit_in      = emit_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = '0;
               rsp_empty_in = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_stat_in  = stat_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         base_ff      <= SYMBOL_BASE_RST;
         used_ff      <= (NW+1)'(1);
         icur_ff      <= '0;
         idep_ff      <= '0;
         qcur_ff      <= '0;
         qv_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         used_ff      <= used_in;
         icur_ff      <= icur_in;
         idep_ff      <= idep_in;
         qcur_ff      <= qcur_in;
         qv_ff        <= qv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      char_ff      <= char_in;
      k_ff         <= k_in;
      node_ff      <= node_in;
      nxt_ff       <= nxt_in;
      scan_ff      <= scan_in;
      len_ff       <= len_in;
      emit_ff      <= emit_in;
      stat_ff      <= stat_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_stat_ff  <= rsp_stat_in;
      if (word_we) word_ff[len_ff[BW-1:0]] <= scan_idx;
   end

endmodule

@@ hdl/tkwl_ram.sv @@
// Synchronous single-write, single-read memory with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tkwl_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
